@@ design/dpwq_pkg.sv @@
// ----------------------------------------------------------------------------
// dpwq_pkg: shared types and constants
// Entry layout, operation and status codes, widths and the sequencer states
// of the deduplicating priority write queue.
// ----------------------------------------------------------------------------
`default_nettype none

package dpwq_pkg;

    localparam int DEPTH     = 128;
    localparam int IDX_W     = $clog2(DEPTH);
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int SUM_W     = IDX_W + 1;

    localparam int NODE_W    = 32;
    localparam int SLOT_W    = 16;
    localparam int CAP_W     = 8;
    localparam int FILL_W    = 8;
    localparam int KIND_W    = 2;
    localparam int STATUS_W  = 3;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(100);

    localparam int S_DATA_W  = 56;
    localparam int M_DATA_W  = 64;

    typedef struct packed {
        logic [NODE_W-1:0] node;
        logic [SLOT_W-1:0] slot;
        logic              prot;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef enum logic [KIND_W-1:0] {
        KIND_ENQ = 2'd0,
        KIND_DEQ = 2'd1,
        KIND_CLR = 2'd2,
        KIND_HAS = 2'd3
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_ADDED   = 3'd0,
        ST_UPDATED = 3'd1,
        ST_FULL    = 3'd2,
        ST_INVALID = 3'd3,
        ST_EMPTY   = 3'd4,
        ST_DONE    = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_RESOLVE,
        S_SHIFT,
        S_FINISH
    } state_t;

endpackage

`default_nettype wire

@@ design/dpwq_ram.sv @@
// ----------------------------------------------------------------------------
// dpwq_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module dpwq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

@@ design/dpwq_pos_unit.sv @@
// ----------------------------------------------------------------------------
// dpwq_pos_unit: shared position unit
// Maps a queue index (0 = oldest) to a store position: one add and one
// compare-subtract against the effective capacity.
// ----------------------------------------------------------------------------
`default_nettype none

module dpwq_pos_unit (
    input  wire logic [dpwq_pkg::IDX_W-1:0] oldest_pos,
    input  wire logic [dpwq_pkg::IDX_W-1:0] idx,
    input  wire logic [dpwq_pkg::CNT_W-1:0] cap,
    output logic      [dpwq_pkg::IDX_W-1:0] pos
);

    import dpwq_pkg::*;

    logic [SUM_W-1:0] sum;
    logic [SUM_W-1:0] cap_ext;
    logic [SUM_W-1:0] wrapped;

    assign sum     = SUM_W'(oldest_pos) + SUM_W'(idx);
    assign cap_ext = SUM_W'(cap);
    assign wrapped = (sum >= cap_ext) ? (sum - cap_ext) : sum;
    assign pos     = wrapped[IDX_W-1:0];

endmodule

`default_nettype wire

@@ design/dedup_priority_write_queue.sv @@
// ----------------------------------------------------------------------------
// dedup_priority_write_queue: bounded write queue with key deduplication
// Keeps pending writes in arrival order, keyed by node id; dequeues the
// oldest protected entry first, else the oldest entry.
// Usage:
//   Input beats arrive on s_t*: tuser carries the operation kind (enqueue,
//   dequeue, clear, contains), tdata the node id, slot and protected mark.
//   Every input beat yields exactly one result beat on m_t*: tuser carries
//   the status, tdata the found flag, dequeued entry and fill level.
//   cfg_wr_en/cfg_wr_data set the capacity and empty the queue; write it
//   only while no operation is in flight.
//   One operation is in flight at a time; s_tready is high only while the
//   sequencer is idle. Lookups run one entry per cycle through a single
//   RAM read port and the shared position unit. Dequeue scans up to the
//   first protected entry at index k, then moves the k older entries one
//   place, one per cycle. Clear, invalid-id enqueue and empty dequeue go
//   straight to the result without a scan.
//   A result waits in the output register while m_tready is low; the next
//   beat is still accepted, and its result is held back until the register
//   frees. Reset empties the queue and loads capacity 100; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module dedup_priority_write_queue (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // tdata: node_id[31:0], slot[47:32], protected_flag[48], zero pad
    input  wire logic [dpwq_pkg::S_DATA_W-1:0]     s_tdata,
    // tuser: kind[1:0]
    input  wire logic [dpwq_pkg::KIND_W-1:0]       s_tuser,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // tdata: found[0], out_node[32:1], out_slot[48:33], out_protected[49],
    //        fill[57:50], zero pad
    output logic      [dpwq_pkg::M_DATA_W-1:0]     m_tdata,
    // tuser: status[2:0]
    output logic      [dpwq_pkg::STATUS_W-1:0]     m_tuser,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    input  wire logic                              cfg_wr_en,
    input  wire logic [dpwq_pkg::CAP_W-1:0]        cfg_wr_data
);

    import dpwq_pkg::*;

    state_t              state_reg, state_next;
    kind_t               op_kind_reg, op_kind_next;
    logic [NODE_W-1:0]   op_node_reg, op_node_next;
    logic [SLOT_W-1:0]   op_slot_reg, op_slot_next;
    logic                op_prot_reg, op_prot_next;

    logic [CAP_W-1:0]    capacity_reg, capacity_next;
    logic [IDX_W-1:0]    oldest_reg, oldest_next;
    logic [IDX_W-1:0]    newest_reg, newest_next;
    logic [CNT_W-1:0]    fill_reg, fill_next;

    logic [CNT_W-1:0]    rd_idx_reg, rd_idx_next;
    logic                cmp_valid_reg, cmp_valid_next;
    logic [CNT_W-1:0]    cmp_idx_reg, cmp_idx_next;
    logic                hit_reg, hit_next;
    logic [IDX_W-1:0]    hit_idx_reg, hit_idx_next;
    entry_t              deq_entry_reg, deq_entry_next;

    logic [IDX_W-1:0]    sh_idx_reg, sh_idx_next;
    logic                iss_reg, iss_next;
    logic                v1_reg, v1_next;
    logic                v2_reg, v2_next;
    logic [IDX_W-1:0]    a1_reg, a1_next;
    logic [IDX_W-1:0]    a2_reg, a2_next;

    status_t             res_status_reg, res_status_next;
    logic                res_found_reg, res_found_next;
    logic                res_deq_reg, res_deq_next;

    logic                m_tvalid_reg, m_tvalid_next;
    logic [M_DATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic [STATUS_W-1:0] m_tuser_reg, m_tuser_next;

    kind_t               in_kind;
    logic [NODE_W-1:0]   in_node;
    logic [SLOT_W-1:0]   in_slot;
    logic                in_prot;
    logic                in_go_finish;
    logic                in_go_scan;

    logic [CNT_W-1:0]    cap_eff;
    logic [IDX_W-1:0]    pos_idx;
    logic [IDX_W-1:0]    pos;
    logic [SUM_W-1:0]    oldest_inc;
    logic [SUM_W-1:0]    newest_inc;
    logic [IDX_W-1:0]    oldest_wrap;
    logic [IDX_W-1:0]    newest_wrap;

    logic                ram_wr_en;
    logic [IDX_W-1:0]    ram_wr_addr;
    logic [ENTRY_W-1:0]  ram_wr_data;
    logic                ram_rd_en;
    logic [ENTRY_W-1:0]  ram_rd_data;
    entry_t              rd_entry;

    logic                match;
    logic                scan_last;
    logic                deq_shift;
    logic                shift_done;
    logic                out_free;
    entry_t              out_entry;

    // ------------------------------------------------------------------
    // input unpacking and decode
    // ------------------------------------------------------------------
    assign in_kind = kind_t'(s_tuser);
    assign in_node = s_tdata[NODE_W-1:0];
    assign in_slot = s_tdata[NODE_W+SLOT_W-1:NODE_W];
    assign in_prot = s_tdata[NODE_W+SLOT_W];

    assign in_go_finish = ((in_kind == KIND_ENQ) && (in_node == '0)) ||
                          ((in_kind == KIND_DEQ) && (fill_reg == '0)) ||
                          (in_kind == KIND_CLR);
    assign in_go_scan   = !in_go_finish && (fill_reg != '0) &&
                          !((in_kind == KIND_HAS) && (in_node == '0));

    always_comb begin
        if (capacity_reg == '0) begin
            cap_eff = CNT_W'(1);
        end else if (int'(capacity_reg) > DEPTH) begin
            cap_eff = CNT_W'(DEPTH);
        end else begin
            cap_eff = CNT_W'(capacity_reg);
        end
    end

    assign oldest_inc  = SUM_W'(oldest_reg) + SUM_W'(1);
    assign newest_inc  = SUM_W'(newest_reg) + SUM_W'(1);
    assign oldest_wrap = (oldest_inc == SUM_W'(cap_eff)) ? '0 : oldest_inc[IDX_W-1:0];
    assign newest_wrap = (newest_inc == SUM_W'(cap_eff)) ? '0 : newest_inc[IDX_W-1:0];

    // ------------------------------------------------------------------
    // shared position unit and entry store
    // ------------------------------------------------------------------
    dpwq_pos_unit u_pos (
        .oldest_pos (oldest_reg),
        .idx        (pos_idx),
        .cap        (cap_eff),
        .pos        (pos)
    );

    dpwq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (pos),
        .rd_data (ram_rd_data)
    );

    assign rd_entry   = entry_t'(ram_rd_data);
    assign match      = (op_kind_reg == KIND_DEQ) ? rd_entry.prot :
                        (rd_entry.node == op_node_reg);
    assign scan_last  = cmp_valid_reg &&
                        (match || ((cmp_idx_reg + CNT_W'(1)) == fill_reg));
    assign deq_shift  = hit_reg && (hit_idx_reg != '0);
    assign shift_done = !iss_reg && !v1_reg;
    assign out_free   = !m_tvalid_reg || m_tready;
    assign out_entry  = res_deq_reg ? deq_entry_reg : '0;

    // ------------------------------------------------------------------
    // sequencer: next state
    // ------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    if (in_go_finish) begin
                        state_next = S_FINISH;
                    end else if (in_go_scan) begin
                        state_next = S_SCAN;
                    end else begin
                        state_next = S_RESOLVE;
                    end
                end
            end
            S_SCAN: begin
                if (scan_last) begin
                    state_next = S_RESOLVE;
                end
            end
            S_RESOLVE: begin
                if ((op_kind_reg == KIND_DEQ) && deq_shift) begin
                    state_next = S_SHIFT;
                end else begin
                    state_next = S_FINISH;
                end
            end
            S_SHIFT: begin
                if (shift_done) begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // sequencer: datapath and outputs
    // ------------------------------------------------------------------
    always_comb begin
        op_kind_next    = op_kind_reg;
        op_node_next    = op_node_reg;
        op_slot_next    = op_slot_reg;
        op_prot_next    = op_prot_reg;
        capacity_next   = capacity_reg;
        oldest_next     = oldest_reg;
        newest_next     = newest_reg;
        fill_next       = fill_reg;
        rd_idx_next     = rd_idx_reg;
        cmp_valid_next  = cmp_valid_reg;
        cmp_idx_next    = cmp_idx_reg;
        hit_next        = hit_reg;
        hit_idx_next    = hit_idx_reg;
        deq_entry_next  = deq_entry_reg;
        sh_idx_next     = sh_idx_reg;
        iss_next        = iss_reg;
        v1_next         = v1_reg;
        v2_next         = v2_reg;
        a1_next         = a1_reg;
        a2_next         = a2_reg;
        res_status_next = res_status_reg;
        res_found_next  = res_found_reg;
        res_deq_next    = res_deq_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tdata_next    = m_tdata_reg;
        m_tuser_next    = m_tuser_reg;

        pos_idx         = rd_idx_reg[IDX_W-1:0];
        ram_rd_en       = 1'b0;
        ram_wr_en       = 1'b0;
        ram_wr_addr     = a2_reg;
        ram_wr_data     = ram_rd_data;

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    op_kind_next    = in_kind;
                    op_node_next    = in_node;
                    op_slot_next    = in_slot;
                    op_prot_next    = in_prot;
                    rd_idx_next     = '0;
                    cmp_valid_next  = 1'b0;
                    hit_next        = 1'b0;
                    hit_idx_next    = '0;
                    res_status_next = ST_DONE;
                    res_found_next  = 1'b0;
                    res_deq_next    = 1'b0;
                    case (in_kind)
                        KIND_ENQ: begin
                            if (in_node == '0) begin
                                res_status_next = ST_INVALID;
                            end
                        end
                        KIND_DEQ: begin
                            if (fill_reg == '0) begin
                                res_status_next = ST_EMPTY;
                            end
                        end
                        KIND_CLR: begin
                            oldest_next = '0;
                            newest_next = '0;
                            fill_next   = '0;
                        end
                        default: ;
                    endcase
                end
            end
            S_SCAN: begin
                pos_idx        = rd_idx_reg[IDX_W-1:0];
                ram_rd_en      = (rd_idx_reg < fill_reg);
                cmp_valid_next = ram_rd_en;
                cmp_idx_next   = rd_idx_reg;
                if (ram_rd_en) begin
                    rd_idx_next = rd_idx_reg + CNT_W'(1);
                end
                if (cmp_valid_reg) begin
                    if ((op_kind_reg == KIND_DEQ) && ((cmp_idx_reg == '0) || match)) begin
                        deq_entry_next = rd_entry;
                    end
                    if (scan_last) begin
                        hit_next     = match;
                        hit_idx_next = cmp_idx_reg[IDX_W-1:0];
                    end
                end
            end
            S_RESOLVE: begin
                pos_idx = hit_idx_reg;
                case (op_kind_reg)
                    KIND_ENQ: begin
                        ram_wr_data = {op_node_reg, op_slot_reg, op_prot_reg};
                        if (hit_reg) begin
                            ram_wr_en       = 1'b1;
                            ram_wr_addr     = pos;
                            res_status_next = ST_UPDATED;
                        end else if (fill_reg >= cap_eff) begin
                            res_status_next = ST_FULL;
                        end else begin
                            ram_wr_en       = 1'b1;
                            ram_wr_addr     = newest_reg;
                            newest_next     = newest_wrap;
                            fill_next       = fill_reg + CNT_W'(1);
                            res_status_next = ST_ADDED;
                        end
                    end
                    KIND_HAS: begin
                        res_found_next = hit_reg;
                    end
                    KIND_DEQ: begin
                        res_deq_next = 1'b1;
                        sh_idx_next  = hit_idx_reg;
                        iss_next     = deq_shift;
                        v1_next      = 1'b0;
                        v2_next      = 1'b0;
                        if (!deq_shift) begin
                            oldest_next = oldest_wrap;
                            fill_next   = fill_reg - CNT_W'(1);
                        end
                    end
                    default: ;
                endcase
            end
            S_SHIFT: begin
                // read pos(j) while writing pos(j+2) with the word read last cycle from pos(j+1)
                pos_idx   = sh_idx_reg;
                ram_rd_en = iss_reg;
                a2_next   = a1_reg;
                v2_next   = v1_reg;
                v1_next   = iss_reg;
                if (iss_reg) begin
                    a1_next = pos;
                    if (sh_idx_reg != '0) begin
                        sh_idx_next = sh_idx_reg - IDX_W'(1);
                    end else begin
                        iss_next = 1'b0;
                    end
                end
                if (v1_reg && v2_reg) begin
                    ram_wr_en   = 1'b1;
                    ram_wr_addr = a2_reg;
                    ram_wr_data = ram_rd_data;
                end
                if (shift_done) begin
                    oldest_next = oldest_wrap;
                    fill_next   = fill_reg - CNT_W'(1);
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = res_status_reg;
                    m_tdata_next  = M_DATA_W'({FILL_W'(fill_reg), out_entry.prot,
                                               out_entry.slot, out_entry.node,
                                               res_found_reg});
                end
            end
            default: ;
        endcase

        if (cfg_wr_en) begin
            capacity_next = cfg_wr_data;
            oldest_next   = '0;
            newest_next   = '0;
            fill_next     = '0;
        end
    end

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            capacity_reg  <= CAP_RESET;
            oldest_reg    <= '0;
            newest_reg    <= '0;
            fill_reg      <= '0;
            cmp_valid_reg <= 1'b0;
            iss_reg       <= 1'b0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            capacity_reg  <= capacity_next;
            oldest_reg    <= oldest_next;
            newest_reg    <= newest_next;
            fill_reg      <= fill_next;
            cmp_valid_reg <= cmp_valid_next;
            iss_reg       <= iss_next;
            v1_reg        <= v1_next;
            v2_reg        <= v2_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_kind_reg    <= op_kind_next;
        op_node_reg    <= op_node_next;
        op_slot_reg    <= op_slot_next;
        op_prot_reg    <= op_prot_next;
        rd_idx_reg     <= rd_idx_next;
        cmp_idx_reg    <= cmp_idx_next;
        hit_reg        <= hit_next;
        hit_idx_reg    <= hit_idx_next;
        deq_entry_reg  <= deq_entry_next;
        sh_idx_reg     <= sh_idx_next;
        a1_reg         <= a1_next;
        a2_reg         <= a2_next;
        res_status_reg <= res_status_next;
        res_found_reg  <= res_found_next;
        res_deq_reg    <= res_deq_next;
        m_tdata_reg    <= m_tdata_next;
        m_tuser_reg    <= m_tuser_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_fill_in_cap : assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= cap_eff)
        else $error("fill level exceeds capacity");

    a_oldest_in_cap : assert property (@(posedge aclk) disable iff (!aresetn)
        SUM_W'(oldest_reg) < SUM_W'(cap_eff))
        else $error("oldest position outside capacity");

    a_newest_in_cap : assert property (@(posedge aclk) disable iff (!aresetn)
        SUM_W'(newest_reg) < SUM_W'(cap_eff))
        else $error("newest position outside capacity");

    a_no_rw_clash : assert property (@(posedge aclk) disable iff (!aresetn)
        (ram_wr_en && ram_rd_en) |-> (ram_wr_addr != pos))
        else $error("store read and write hit the same position");

    a_shift_needs_two : assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SHIFT) |-> (fill_reg >= CNT_W'(2)))
        else $error("entry move with fewer than two entries queued");

endmodule

`default_nettype wire

@@ test/dpwq_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dpwq_checker: result predictor and scoreboard for the write queue
// Watches the input, result and capacity ports. Every accepted input beat is
// run through a behavioral copy of the queue (arrival order, id dedup,
// protected-first dequeue with compaction). Each result beat is compared
// field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module dpwq_checker (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic [dpwq_pkg::S_DATA_W-1:0]     s_tdata,
    input  logic [dpwq_pkg::KIND_W-1:0]       s_tuser,
    input  logic                              s_tvalid,
    input  logic                              s_tready,
    input  logic [dpwq_pkg::M_DATA_W-1:0]     m_tdata,
    input  logic [dpwq_pkg::STATUS_W-1:0]     m_tuser,
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic                              cfg_wr_en,
    input  logic [dpwq_pkg::CAP_W-1:0]        cfg_wr_data,
    output int                                errors,
    output int                                pending
);
    import dpwq_pkg::*;

    typedef struct packed {
        status_t           status;
        logic              found;
        logic [NODE_W-1:0] node;
        logic [SLOT_W-1:0] slot;
        logic              prot;
        logic [FILL_W-1:0] fill;
    } outcome_t;

    logic [NODE_W-1:0] q_node [DEPTH];
    logic [SLOT_W-1:0] q_slot [DEPTH];
    logic              q_prot [DEPTH];
    int unsigned       head_pos;
    int unsigned       tail_pos;
    int unsigned       count;
    int unsigned       cap_reg;
    int                fail_count = 0;
    outcome_t          outcome_q [$];

    assign errors = fail_count;

    function automatic int unsigned eff_cap();
        int unsigned c;
        c = cap_reg;
        if (c == 0) c = 1;
        if (c > DEPTH) c = DEPTH;
        return c;
    endfunction

    function automatic int unsigned pos_at(int unsigned i);
        return (head_pos + i) % eff_cap();
    endfunction

    function automatic int unsigned locate(logic [NODE_W-1:0] id);
        for (int unsigned i = 0; i < count; i++) begin
            if (q_node[pos_at(i)] == id) return i;
        end
        return count;
    endfunction

    task automatic run_queue_op(input kind_t kind, input logic [NODE_W-1:0] id,
                                input logic [SLOT_W-1:0] slot, input logic prot,
                                output outcome_t res);
        int unsigned c;
        int unsigned k;
        int unsigned p;
        int unsigned best;
        int unsigned dst;
        int unsigned src;
        logic        hit;
        c = eff_cap();
        res = '0;
        res.status = ST_DONE;
        case (kind)
            KIND_ENQ: begin
                if (id == '0) begin
                    res.status = ST_INVALID;
                end else begin
                    k = locate(id);
                    if (k < count) begin
                        p = pos_at(k);
                        q_slot[p] = slot;
                        q_prot[p] = prot;
                        res.status = ST_UPDATED;
                    end else if (count >= c) begin
                        res.status = ST_FULL;
                    end else begin
                        p = tail_pos % c;
                        q_node[p] = id;
                        q_slot[p] = slot;
                        q_prot[p] = prot;
                        tail_pos = (p + 1) % c;
                        count++;
                        res.status = ST_ADDED;
                    end
                end
            end
            KIND_DEQ: begin
                if (count == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    best = 0;
                    hit = 1'b0;
                    for (int unsigned i = 0; i < count; i++) begin
                        if (!hit && q_prot[pos_at(i)]) begin
                            best = i;
                            hit = 1'b1;
                        end
                    end
                    p = pos_at(best);
                    res.node = q_node[p];
                    res.slot = q_slot[p];
                    res.prot = q_prot[p];
                    // shift older entries one place toward the newer end
                    for (int unsigned i = best; i > 0; i--) begin
                        dst = pos_at(i);
                        src = pos_at(i - 1);
                        q_node[dst] = q_node[src];
                        q_slot[dst] = q_slot[src];
                        q_prot[dst] = q_prot[src];
                    end
                    head_pos = (head_pos + 1) % c;
                    count--;
                end
            end
            KIND_CLR: begin
                head_pos = 0;
                tail_pos = 0;
                count = 0;
            end
            default: begin
                res.found = (id != '0) && (locate(id) < count);
            end
        endcase
        res.fill = FILL_W'(count);
    endtask

    task automatic check_field(string name, longint unsigned want, longint unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin : watch
        outcome_t want;
        outcome_t got;
        if (!aresetn) begin
            head_pos = 0;
            tail_pos = 0;
            count = 0;
            cap_reg = CAP_RESET;
            outcome_q.delete();
            pending <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (outcome_q.size() == 0) begin
                    $error("result beat with no operation pending");
                    fail_count++;
                end else begin
                    want = outcome_q.pop_front();
                    check_field("status", want.status, m_tuser);
                    check_field("found", want.found, m_tdata[0]);
                    check_field("out_node", want.node, m_tdata[32:1]);
                    check_field("out_slot", want.slot, m_tdata[48:33]);
                    check_field("out_protected", want.prot, m_tdata[49]);
                    check_field("fill", want.fill, m_tdata[57:50]);
                    check_field("pad", 0, m_tdata[63:58]);
                end
            end
            if (cfg_wr_en) begin
                cap_reg = cfg_wr_data;
                head_pos = 0;
                tail_pos = 0;
                count = 0;
            end
            if (s_tvalid && s_tready) begin
                run_queue_op(kind_t'(s_tuser), s_tdata[31:0], s_tdata[47:32], s_tdata[48],
                             got);
                outcome_q.push_back(got);
            end
            pending <= outcome_q.size();
        end
    end

endmodule

@@ test/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: stimulus and verdict for dedup_priority_write_queue
// Drives a directed opening (empty, invalid id, dedup update, protected-first
// dequeue, clear, capacity limits and the queue flush on a capacity write),
// then random phases across several capacities with random source gaps and
// result-side stalls. The checker instance predicts and compares results.
// ----------------------------------------------------------------------------
module tb;
    import dpwq_pkg::*;

    logic                aclk        = 1'b0;
    logic                aresetn     = 1'b0;
    logic [S_DATA_W-1:0] s_tdata     = '0;
    logic [KIND_W-1:0]   s_tuser     = '0;
    logic                s_tvalid    = 1'b0;
    logic                s_tready;
    logic [M_DATA_W-1:0] m_tdata;
    logic [STATUS_W-1:0] m_tuser;
    logic                m_tvalid;
    logic                m_tready    = 1'b0;
    logic                cfg_wr_en   = 1'b0;
    logic [CAP_W-1:0]    cfg_wr_data = '0;
    int                  errors;
    int                  pending;
    logic                calm        = 1'b0;
    int                  ready_left  = 0;

    dedup_priority_write_queue dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    dpwq_checker mon (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .errors      (errors),
        .pending     (pending)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    initial begin
        #(12_000_000);
        $display("TB_ERROR");
        $finish;
    end

    // result-side stalls: mostly short, a few long
    always @(posedge aclk) begin
        if (ready_left > 0) begin
            ready_left = ready_left - 1;
        end else if (calm || $urandom_range(0, 2) != 0) begin
            m_tready <= 1'b1;
            ready_left = $urandom_range(0, 30);
        end else begin
            m_tready <= 1'b0;
            ready_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 64)
                                                     : $urandom_range(0, 3);
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [NODE_W-1:0] pick_id(int pool);
        int          r;
        logic [15:0] k;
        r = $urandom_range(0, 99);
        if (r < 4) return '0;
        if (r < 10) return $urandom;
        if (r < 12) return 32'hFFFF_FFFF - $urandom_range(0, 3);
        k = 16'($urandom_range(1, pool));
        return {k ^ 16'hA5C3, k};
    endfunction

    task automatic send_op(kind_t kind, logic [NODE_W-1:0] id, logic [SLOT_W-1:0] slot,
                           logic prot);
        int gap;
        s_tuser  <= kind;
        s_tdata  <= {7'd0, prot, slot, id};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            s_tdata  <= S_DATA_W'({$urandom, $urandom});
            s_tuser  <= KIND_W'($urandom);
            repeat (gap) @(posedge aclk);
        end
    endtask

    // drop valid and wait until every result beat has come back
    task automatic settle();
        s_tvalid <= 1'b0;
        repeat (2) @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_capacity(logic [CAP_W-1:0] cap);
        settle();
        cfg_wr_data <= cap;
        cfg_wr_en   <= 1'b1;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        @(posedge aclk);
    endtask

    initial begin : stim
        logic [CAP_W-1:0] caps [10];
        int               enq;
        int               deq;
        int               clr;
        int               pool;
        int               r;
        logic             full_run;
        kind_t            kind;

        caps = '{8'd1, 8'd2, 8'd128, 8'd200, 8'd3, 8'd100, 8'd255, 8'd17, 8'd0, 8'd64};
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_op(KIND_DEQ, 32'd0, 16'd0, 1'b0);
        send_op(KIND_HAS, 32'd0, 16'd0, 1'b0);
        send_op(KIND_ENQ, 32'd0, 16'hFFFF, 1'b1);
        send_op(KIND_ENQ, 32'hFFFF_FFFF, 16'hFFFF, 1'b1);
        send_op(KIND_ENQ, 32'd1, 16'd0, 1'b0);
        send_op(KIND_ENQ, 32'd1, 16'h1234, 1'b1);
        send_op(KIND_HAS, 32'hFFFF_FFFF, 16'd0, 1'b0);
        send_op(KIND_HAS, 32'd2, 16'd0, 1'b0);
        send_op(KIND_ENQ, 32'd2, 16'h00FF, 1'b0);
        send_op(KIND_ENQ, 32'd3, 16'hFF00, 1'b0);
        send_op(KIND_DEQ, 32'd0, 16'd0, 1'b0);
        send_op(KIND_DEQ, 32'd0, 16'd0, 1'b0);
        send_op(KIND_DEQ, 32'd0, 16'd0, 1'b0);
        send_op(KIND_CLR, 32'd0, 16'd0, 1'b0);
        send_op(KIND_DEQ, 32'd0, 16'd0, 1'b0);

        set_capacity(8'd0);
        send_op(KIND_ENQ, 32'd5, 16'd7, 1'b0);
        send_op(KIND_ENQ, 32'd6, 16'd8, 1'b0);
        send_op(KIND_ENQ, 32'd5, 16'd9, 1'b1);
        send_op(KIND_HAS, 32'd6, 16'd0, 1'b0);
        send_op(KIND_DEQ, 32'd0, 16'd0, 1'b0);
        send_op(KIND_ENQ, 32'd7, 16'd1, 1'b1);
        set_capacity(8'd255);
        send_op(KIND_DEQ, 32'd0, 16'd0, 1'b0);

        for (int ph = 0; ph < 10; ph++) begin
            full_run = (ph == 2 || ph == 6);
            enq  = full_run ? 92 : ((ph % 2) ? 45 : 70);
            deq  = full_run ? 4 : ((ph % 2) ? 40 : 20);
            clr  = full_run ? 0 : 2;
            pool = (caps[ph] <= 3) ? 6 : (full_run ? 400 : ((ph % 2) ? 30 : 150));
            set_capacity(caps[ph]);
            calm = (ph == 4 || ph == 7);
            for (int n = 0; n < 173; n++) begin
                r = $urandom_range(0, 99);
                if (r < enq) kind = KIND_ENQ;
                else if (r < enq + deq) kind = KIND_DEQ;
                else if (r < enq + deq + clr) kind = KIND_CLR;
                else kind = KIND_HAS;
                send_op(kind, pick_id(pool), 16'($urandom), ($urandom_range(0, 3) == 0));
            end
        end

        settle();
        repeat (8) @(posedge aclk);
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

@@ sim.f @@
design/dpwq_pkg.sv
design/dpwq_ram.sv
design/dpwq_pos_unit.sv
design/dedup_priority_write_queue.sv
test/dpwq_checker.sv
test/tb.sv
